// ===== rtl/ssis_pkg.sv =====
// Shared types and constants for the sorted set intersect/subtract block.
// No dependencies; every other file in rtl/ but ssis_ram imports this package.
package ssis_pkg;

    localparam int KEY_W       = 64;
    localparam int OCC_W       = 32;
    localparam int INDEX_W     = 10;
    localparam int QUEUE_DEPTH = 2;

    // Input command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Mode register codes
    localparam logic [1:0] MODE_INTERSECT = 2'd0;
    localparam logic [1:0] MODE_SUBTRACT  = 2'd1;
    localparam logic [1:0] MODE_SEARCH    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [OCC_W-1:0] occurrences;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   out_key;
        logic [OCC_W-1:0]   out_occurrences;
        logic               hit;
        logic [INDEX_W-1:0] hit_index;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [OCC_W-1:0] occurrences;
    } job_t;

    // One queue port: an item and its valid flag
    typedef struct packed {
        logic valid;
        job_t job;
    } job_port_t;

endpackage

// ===== rtl/ssis_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module ssis_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/ssis_front.sv =====
// Front end: accepts input items, classifies the command, drops reserved codes.
// Depends on ssis_pkg.
module ssis_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  ssis_pkg::in_item_t in_item,
    input  logic               queue_full,
    output ssis_pkg::job_port_t push
);
    import ssis_pkg::*;

    logic keep;
    op_t  op;

    always_comb
    begin
        keep = 1'b1;
        op   = OP_QUERY;
        unique case (in_item.cmd)
            CMD_LOAD:  op = OP_LOAD;
            CMD_QUERY: op = OP_QUERY;
            CMD_CLEAR: op = OP_CLEAR;
            default:   keep = 1'b0;
        endcase
    end

    assign in_stall             = queue_full;
    assign push.valid           = in_valid && !queue_full && keep;
    assign push.job.op          = op;
    assign push.job.key         = in_item.key;
    assign push.job.occurrences = in_item.occurrences;

endmodule

// ===== rtl/ssis_queue.sv =====
// Short FIFO of classified jobs between the front end and the search engine.
// Depends on ssis_pkg.
module ssis_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ssis_pkg::job_port_t push,
    output logic                full,
    output ssis_pkg::job_port_t head,
    input  logic                pop
);
    import ssis_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/ssis_back.sv =====
// Back end: executes loads and clears, binary-searches the table for queries,
// holds the result in an output register. Depends on ssis_pkg and ssis_ram.
module ssis_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssis_pkg::job_port_t head,
    output logic                pop,
    input  logic [1:0]          mode,
    output logic                out_valid,
    input  logic                out_stall,
    output ssis_pkg::out_item_t out_item
);
    import ssis_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int ROW_W = KEY_W + OCC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_LAST,
        S_DONE
    } state_t;

    state_t           state_reg,  state_next;
    logic [AW:0]      filled_reg, filled_next;
    logic [AW:0]      lo_reg,     lo_next;
    logic [AW:0]      hi_reg,     hi_next;
    logic [AW-1:0]    x_reg,      x_next;
    logic [AW-1:0]    pos_reg,    pos_next;
    logic             found_reg,  found_next;
    logic [KEY_W-1:0] key_reg,    key_next;
    logic [OCC_W-1:0] occ_reg,    occ_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg,  out_item_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;

    logic [KEY_W-1:0] rd_key;
    logic [OCC_W-1:0] rd_cnt;
    logic [AW:0]      lo_n;
    logic [AW:0]      hi_n;
    logic [AW+1:0]    mid_sum;
    logic [AW-1:0]    mid;
    logic [OCC_W:0]   sum;
    logic [OCC_W-1:0] sum_sat;
    logic [AW+INDEX_W-1:0] pos_wide;
    logic             emit;
    logic             out_take;

    ssis_ram #(
        .WIDTH(ROW_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_key   = ram_rdata[ROW_W-1 -: KEY_W];
    assign rd_cnt   = ram_rdata[OCC_W-1:0];
    assign out_take = out_valid_reg && !out_stall;

    // Narrow the current window around the probed entry
    always_comb
    begin
        lo_n = lo_reg;
        hi_n = hi_reg;
        if (key_reg < rd_key)
        begin
            hi_n = {1'b0, x_reg};
        end
        else
        begin
            lo_n = {1'b0, x_reg};
        end
        mid_sum = {1'b0, hi_n} + {1'b0, lo_n};
        mid     = mid_sum[AW:1];
    end

    always_comb
    begin
        sum      = {1'b0, occ_reg} + {1'b0, rd_cnt};
        sum_sat  = sum[OCC_W] ? '1 : sum[OCC_W-1:0];
        pos_wide = {{INDEX_W{1'b0}}, pos_reg};
        emit     = 1'b0;
        unique case (mode)
            MODE_INTERSECT: emit = found_reg;
            MODE_SUBTRACT:  emit = !found_reg;
            MODE_SEARCH:    emit = 1'b1;
            default:        emit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        occ_next       = occ_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_waddr      = filled_reg[AW-1:0];
        ram_wdata      = {head.job.key, head.job.occurrences};
        ram_re         = 1'b0;
        ram_raddr      = x_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.job.op)
                        OP_LOAD:
                        begin
                            // drop the entry when the table is full
                            if (filled_reg < (AW+1)'(TABLE_DEPTH))
                            begin
                                ram_we      = 1'b1;
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            filled_next = '0;
                        end
                        OP_QUERY:
                        begin
                            key_next   = head.job.key;
                            occ_next   = head.job.occurrences;
                            found_next = 1'b0;
                            pos_next   = '0;
                            lo_next    = '0;
                            hi_next    = filled_reg;
                            x_next     = filled_reg[AW:1];
                            if (filled_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else if (filled_reg == (AW+1)'(1))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_LAST;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = filled_reg[AW:1];
                                state_next = S_PROBE;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = x_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    lo_next = lo_n;
                    hi_next = hi_n;
                    x_next  = mid;
                    if ((hi_n - lo_n) > (AW+1)'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = mid;
                    end
                    else if (mid == '0)
                    begin
                        // entry 0 is tested last
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_LAST;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LAST:
            begin
                found_next = (rd_key == key_reg);
                pos_next   = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!emit)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_take)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.out_key         = key_reg;
                    out_item_next.out_occurrences =
                        (mode == MODE_INTERSECT) ? sum_sat : occ_reg;
                    out_item_next.hit             = found_reg;
                    out_item_next.hit_index       =
                        found_reg ? pos_wide[INDEX_W-1:0] : '0;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        key_reg      <= key_next;
        occ_reg      <= occ_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/sorted_set_intersect_subtract.sv =====
// Top level of the sorted set intersect/subtract block.
// Depends on ssis_pkg, ssis_front, ssis_queue and ssis_back.

// The host loads ascending, unique keys with their counts (cmd 0), clears the
// table (cmd 2) and sends queries (cmd 1); each query is binary-searched in a
// TABLE_DEPTH-entry table held in one RAM. A two-entry queue separates the
// input from the search engine, and an output register holds the result, so
// the input keeps flowing while a result waits, until the queue fills.
// A query is started, then probed (each probe is a dependent RAM read and a
// 64-bit compare), with one more probe when entry 0 is tested last, and then
// its result is formed. The user must write mode through cfg_we/cfg_data
// only while no item is in flight; the block itself does not enforce this.
module sorted_set_intersect_subtract #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ssis_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output ssis_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data
);
    import ssis_pkg::*;

    logic [1:0] mode_reg;
    logic       queue_full;
    logic       job_pop;
    job_port_t  push;
    job_port_t  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_INTERSECT;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    ssis_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push)
    );

    ssis_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (job_pop)
    );

    ssis_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (job_pop),
        .mode      (mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // The engine takes a job only from a non-empty queue
    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> head.valid)
        else $error("job popped from an empty queue");

    // A miss never reports a position
    a_miss_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.hit) |-> (out_item.hit_index == '0))
        else $error("miss reported with a nonzero index");

    // A full queue never takes a push
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push.valid)
        else $error("push into a full queue");

endmodule
